[sv/weo_pkg.sv]
package weo_pkg;

  // Request and pose payloads
  typedef struct packed {
    logic        cmd;
    logic [15:0] left_count;
    logic [15:0] right_count;
  } odo_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic [1:0]         motion_case;
  } odo_pose_t;

  // Request commands
  localparam logic CMD_POLL   = 1'b0;
  localparam logic CMD_COMMIT = 1'b1;

  // Motion cases
  localparam logic [1:0] MC_SPOT     = 2'd0;
  localparam logic [1:0] MC_STRAIGHT = 2'd1;
  localparam logic [1:0] MC_RIGHT    = 2'd2;
  localparam logic [1:0] MC_LEFT     = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_TPT  = 2'd0;
  localparam logic [1:0] REG_TPC  = 2'd1;
  localparam logic [1:0] REG_BASE = 2'd2;
  localparam logic [1:0] REG_THR  = 2'd3;

  // Encoder wrap handling
  localparam int HALF_SWING = 16384;
  localparam int COUNT_SPAN = 65536;

  // Multiply and divide unit
  localparam int ALU_AW    = 68;
  localparam int ALU_BW    = 36;
  localparam int MUL_ITERS = 36;
  localparam int DIV_ITERS = 68;
  localparam int ALU_CW    = $clog2(DIV_ITERS + 1);
  localparam logic ALU_MUL = 1'b0;
  localparam logic ALU_DIV = 1'b1;

  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  typedef struct packed {
    logic              start;
    logic              op;
    logic [ALU_AW-1:0] a;
    logic [ALU_BW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [ALU_AW-1:0] value;
  } alu_rsp_t;

  // CORDIC
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int CORDIC_SW    = $clog2(CORDIC_RUN);
  localparam int TRIG_W       = 34;
  localparam int ZANG_W       = 33;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } trig_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_rsp_t;

  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[sv/weo_alu.sv]
module weo_alu (
  input  logic              clk,
  input  logic              rst,
  input  weo_pkg::alu_req_t req,
  output weo_pkg::alu_rsp_t rsp
);

  logic                        busy;
  logic                        done;
  logic                        op;
  logic [weo_pkg::ALU_CW-1:0]  cnt;
  logic [weo_pkg::ALU_AW-1:0]  opa;
  logic [weo_pkg::ALU_BW-1:0]  opb;
  logic [weo_pkg::ALU_AW-1:0]  prod;
  logic [weo_pkg::ALU_BW-1:0]  rem;
  logic [weo_pkg::ALU_BW:0]    rem_sh;
  logic [weo_pkg::ALU_BW+1:0]  trial;
  logic                        qbit;
  logic [weo_pkg::ALU_BW-1:0]  rem_next;

  // One restoring divide step: shift in the next dividend bit, try the subtract
  assign rem_sh   = {rem, opa[weo_pkg::ALU_AW-1]};
  assign trial    = {1'b0, rem_sh} - {2'b00, opb};
  assign qbit     = !trial[weo_pkg::ALU_BW+1];
  assign rem_next = qbit ? trial[weo_pkg::ALU_BW-1:0] : rem_sh[weo_pkg::ALU_BW-1:0];

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= (req.op == weo_pkg::ALU_DIV) ? weo_pkg::ALU_CW'(weo_pkg::DIV_ITERS)
                                             : weo_pkg::ALU_CW'(weo_pkg::MUL_ITERS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == weo_pkg::ALU_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift-add multiply or restoring divide, one bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      opa  <= req.a;
      opb  <= req.b;
      prod <= '0;
      rem  <= '0;
    end else if (busy) begin
      if (op == weo_pkg::ALU_DIV) begin
        rem <= rem_next;
        opa <= {opa[weo_pkg::ALU_AW-2:0], qbit};
      end else begin
        if (opb[0]) prod <= prod + opa;
        opa <= {opa[weo_pkg::ALU_AW-2:0], 1'b0};
        opb <= {1'b0, opb[weo_pkg::ALU_BW-1:1]};
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.value = (op == weo_pkg::ALU_DIV) ? opa : prod;

endmodule

[sv/weo_cordic.sv]
module weo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  weo_pkg::trig_req_t req,
  output weo_pkg::trig_rsp_t rsp
);

  logic                                 busy;
  logic                                 done;
  logic [weo_pkg::CORDIC_SW-1:0]        step;
  logic signed [weo_pkg::TRIG_W-1:0]    x;
  logic signed [weo_pkg::TRIG_W-1:0]    y;
  logic signed [weo_pkg::ZANG_W-1:0]    z;
  logic [1:0]                           quad;
  logic signed [weo_pkg::TRIG_W-1:0]    dx;
  logic signed [weo_pkg::TRIG_W-1:0]    dy;
  logic signed [weo_pkg::ZANG_W-1:0]    at;

  assign dx = y >>> step;
  assign dy = x >>> step;
  assign at = $signed({3'b000, weo_pkg::atan_entry(5'(step))});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == weo_pkg::CORDIC_SW'(weo_pkg::CORDIC_RUN - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Reduce to within an eighth turn, then rotate one micro-step a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= weo_pkg::CORDIC_X0;
      y    <= '0;
      z    <= $signed({{3{req.angle[29]}}, req.angle[29:0]});
      quad <= req.angle[31:30] + {1'b0, req.angle[29]};
    end else if (busy) begin
      if (!z[weo_pkg::ZANG_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - at;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + at;
      end
    end
  end

  // Map back to the full circle
  always_comb begin
    rsp.done = done;
    unique case (quad)
      2'd0: begin rsp.cos_v = x;  rsp.sin_v = y;  end
      2'd1: begin rsp.cos_v = -y; rsp.sin_v = x;  end
      2'd2: begin rsp.cos_v = -x; rsp.sin_v = -y; end
      default: begin rsp.cos_v = y; rsp.sin_v = -x; end
    endcase
  end

endmodule

[sv/wheel_encoder_odometry_unit.sv]
// Differential drive odometry. A poll request carries raw 16-bit wheel counts; their
// wrap-corrected deltas add to accumulators kept since the reference pose, and each
// request returns one pose estimate (spot rotation, straight line, or left/right arc).
// A commit request returns the estimate and latches it as the new reference. One request
// is worked at a time by a sequencer around one bit-serial multiply/divide unit and one
// iterative CORDIC. req_stall stays high while a request is worked; a finished pose
// waits in the output register, so the next request may enter before it is taken.
module wheel_encoder_odometry_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  weo_pkg::odo_req_t  req,
  output logic               pose_valid,
  input  logic               pose_stall,
  output weo_pkg::odo_pose_t pose,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CLASS    = 4'd1;
  localparam logic [3:0] ST_ROT_DIV  = 4'd2;
  localparam logic [3:0] ST_DIST_DIV = 4'd3;
  localparam logic [3:0] ST_PHI_MUL  = 4'd4;
  localparam logic [3:0] ST_PHI_DIV  = 4'd5;
  localparam logic [3:0] ST_RAD_DIV  = 4'd6;
  localparam logic [3:0] ST_TRIG0    = 4'd7;
  localparam logic [3:0] ST_TRIG1    = 4'd8;
  localparam logic [3:0] ST_MUL_X    = 4'd9;
  localparam logic [3:0] ST_MUL_Y    = 4'd10;
  localparam logic [3:0] ST_FINISH   = 4'd11;

  // Configuration
  logic [15:0] tpt;
  logic [15:0] tpc;
  logic [9:0]  wbase;
  logic [9:0]  thr;

  // Odometry state
  logic [3:0]  state;
  logic        issued;
  logic        cmd_r;
  logic        seen_first;
  logic [15:0] prev_left;
  logic [15:0] prev_right;
  logic [31:0] acc_left;
  logic [31:0] acc_right;
  logic signed [31:0] ref_x;
  logic signed [31:0] ref_y;
  logic [15:0] ref_heading;

  // Estimate working registers
  logic signed [25:0] l_r;
  logic signed [26:0] sum_r;
  logic signed [26:0] diff_r;
  logic [25:0] asum_r;
  logic [25:0] adiff_r;
  logic [1:0]  mc_r;
  logic [31:0] nh_r;
  logic [32:0] rc_mag;
  logic        rc_neg;
  logic signed [weo_pkg::TRIG_W-1:0] c0_r;
  logic signed [weo_pkg::TRIG_W-1:0] s0_r;
  logic signed [35:0] t_x;
  logic signed [35:0] t_y;
  logic signed [35:0] dx_r;
  logic signed [35:0] dy_r;

  weo_pkg::alu_req_t  alu_req;
  weo_pkg::alu_rsp_t  alu_rsp;
  weo_pkg::trig_req_t trig_req;
  weo_pkg::trig_rsp_t trig_rsp;

  // APB register port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpt   <= 16'd1608;
      tpc   <= 16'd5780;
      wbase <= 10'd250;
      thr   <= 10'd20;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        weo_pkg::REG_TPT:  tpt   <= pwdata[15:0];
        weo_pkg::REG_TPC:  tpc   <= pwdata[15:0];
        weo_pkg::REG_BASE: wbase <= pwdata[9:0];
        default:           thr   <= pwdata[9:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      weo_pkg::REG_TPT:  prdata = {16'd0, tpt};
      weo_pkg::REG_TPC:  prdata = {16'd0, tpc};
      weo_pkg::REG_BASE: prdata = {22'd0, wbase};
      default:           prdata = {22'd0, thr};
    endcase
  end

  // Zero divisor registers act as one
  logic [15:0] tpt_eff;
  logic [15:0] tpc_eff;
  logic [9:0]  base_eff;
  assign tpt_eff  = (tpt == 16'd0) ? 16'd1 : tpt;
  assign tpc_eff  = (tpc == 16'd0) ? 16'd1 : tpc;
  assign base_eff = (wbase == 10'd0) ? 10'd1 : wbase;

  // Wrap-corrected deltas
  function automatic logic [31:0] wrap_delta(input logic [15:0] now, input logic [15:0] old);
    logic signed [17:0] d;
    d = $signed({2'b00, now}) - $signed({2'b00, old});
    if (d < -18'sd16384)     d = d + 18'(weo_pkg::COUNT_SPAN);
    else if (d > 18'sd16384) d = d - 18'(weo_pkg::COUNT_SPAN);
    return {{14{d[17]}}, d};
  endfunction

  function automatic logic signed [25:0] clamp_est(input logic [31:0] v);
    logic signed [25:0] c;
    if ($signed(v) > 32'sd16777216)       c = 26'sd16777216;
    else if ($signed(v) < -32'sd16777216) c = -26'sd16777216;
    else                                   c = v[25:0];
    return c;
  endfunction

  function automatic logic [32:0] clamp_travel(input logic [weo_pkg::ALU_AW-1:0] q);
    return (q > weo_pkg::ALU_AW'(64'h1_0000_0000)) ? 33'h1_0000_0000 : q[32:0];
  endfunction

  // Classification of the accumulated travel
  logic signed [25:0] l_c;
  logic signed [25:0] r_c;
  logic signed [26:0] sum_c;
  logic signed [26:0] diff_c;
  logic [26:0] asum_w;
  logic [26:0] adiff_w;
  assign l_c     = clamp_est(acc_left);
  assign r_c     = clamp_est(acc_right);
  assign sum_c   = {l_c[25], l_c} + {r_c[25], r_c};
  assign diff_c  = {l_c[25], l_c} - {r_c[25], r_c};
  assign asum_w  = sum_c[26] ? -sum_c : sum_c;
  assign adiff_w = diff_c[26] ? -diff_c : diff_c;

  // Operands for the shared unit
  logic [31:0] h;
  logic [25:0] al_w;
  logic [37:0] phi_num;
  logic [25:0] phi_den;
  logic [35:0] rad_num;
  logic [36:0] rad_den;
  logic [22:0] dist_den;
  logic [35:0] tx_abs;
  logic [35:0] ty_abs;
  logic        alu_state;

  assign h        = {ref_heading, 16'd0};
  assign al_w     = l_r[25] ? -l_r : l_r;
  assign phi_num  = {1'b0, adiff_r, 11'd0} + {3'b000, adiff_r, 9'd0};
  assign phi_den  = 26'(tpc_eff) * 26'(base_eff);
  assign rad_num  = 36'(base_eff) * 36'(asum_r);
  assign rad_den  = {adiff_r, 11'd0} - {6'd0, adiff_r, 5'd0} - {7'd0, adiff_r, 4'd0};
  assign dist_den = 23'(tpc_eff) * 23'd100;
  assign tx_abs   = t_x[35] ? -t_x : t_x;
  assign ty_abs   = t_y[35] ? -t_y : t_y;
  assign alu_state = (state == ST_ROT_DIV) || (state == ST_DIST_DIV) ||
                     (state == ST_PHI_MUL) || (state == ST_PHI_DIV) ||
                     (state == ST_RAD_DIV) || (state == ST_MUL_X) || (state == ST_MUL_Y);

  always_comb begin
    alu_req.start = alu_state && !issued;
    alu_req.op    = weo_pkg::ALU_DIV;
    alu_req.a     = '0;
    alu_req.b     = '0;
    unique case (state)
      ST_ROT_DIV: begin
        alu_req.a = weo_pkg::ALU_AW'({al_w[24:0], 32'd0});
        alu_req.b = weo_pkg::ALU_BW'(tpt_eff);
      end
      ST_DIST_DIV: begin
        alu_req.a = weo_pkg::ALU_AW'({asum_r, 23'd0});
        alu_req.b = weo_pkg::ALU_BW'(dist_den);
      end
      ST_PHI_MUL: begin
        alu_req.op = weo_pkg::ALU_MUL;
        alu_req.a  = weo_pkg::ALU_AW'(phi_num);
        alu_req.b  = weo_pkg::ALU_BW'(weo_pkg::INV_TWO_PI_Q32);
      end
      ST_PHI_DIV: begin
        alu_req.a = alu_rsp.value;
        alu_req.b = weo_pkg::ALU_BW'(phi_den);
      end
      ST_RAD_DIV: begin
        alu_req.a = weo_pkg::ALU_AW'({rad_num, 16'd0});
        alu_req.b = rad_den[35:0];
      end
      ST_MUL_X: begin
        alu_req.op = weo_pkg::ALU_MUL;
        alu_req.a  = weo_pkg::ALU_AW'(rc_mag);
        alu_req.b  = tx_abs;
      end
      ST_MUL_Y: begin
        alu_req.op = weo_pkg::ALU_MUL;
        alu_req.a  = weo_pkg::ALU_AW'(rc_mag);
        alu_req.b  = ty_abs;
      end
      default: begin
        alu_req.op = weo_pkg::ALU_DIV;
      end
    endcase
  end

  assign trig_req.start = ((state == ST_TRIG0) || (state == ST_TRIG1)) && !issued;
  assign trig_req.angle = (state == ST_TRIG1) ? nh_r : h;

  weo_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  weo_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (trig_req),
    .rsp (trig_rsp)
  );

  // Round a Q30 product and apply the sign
  logic [weo_pkg::ALU_AW-1:0] prod_rnd;
  logic [35:0] prod_mag;
  logic signed [35:0] delta_x;
  logic signed [35:0] delta_y;
  assign prod_rnd = alu_rsp.value + weo_pkg::ALU_AW'(64'h2000_0000);
  assign prod_mag = prod_rnd[65:30];
  assign delta_x  = (rc_neg ^ t_x[35]) ? -prod_mag : prod_mag;
  assign delta_y  = (rc_neg ^ t_y[35]) ? -prod_mag : prod_mag;

  // Final pose
  logic signed [35:0] px_w;
  logic signed [35:0] py_w;
  logic signed [31:0] px_sat;
  logic signed [31:0] py_sat;
  logic [31:0] hd_w;
  logic        unit_done;
  logic        out_free;

  assign px_w   = {{4{ref_x[31]}}, ref_x} + dx_r;
  assign py_w   = {{4{ref_y[31]}}, ref_y} + dy_r;
  assign px_sat = (px_w > 36'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (px_w < -36'sh0_8000_0000) ? 32'sh8000_0000 : px_w[31:0];
  assign py_sat = (py_w > 36'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                  (py_w < -36'sh0_8000_0000) ? 32'sh8000_0000 : py_w[31:0];
  assign hd_w   = nh_r + 32'h0000_8000;
  assign unit_done = alu_state ? alu_rsp.done : trig_rsp.done;
  assign out_free  = !pose_valid || !pose_stall;

  assign req_stall = (state != ST_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issued      <= 1'b0;
      pose_valid  <= 1'b0;
      seen_first  <= 1'b0;
      prev_left   <= '0;
      prev_right  <= '0;
      acc_left    <= '0;
      acc_right   <= '0;
      ref_x       <= '0;
      ref_y       <= '0;
      ref_heading <= '0;
    end else begin
      // Drop a taken pose unless a new one replaces it this cycle
      if (pose_valid && !pose_stall && state != ST_FINISH) pose_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cmd_r <= req.cmd;
            if (req.cmd == weo_pkg::CMD_POLL) begin
              if (seen_first) begin
                acc_left  <= acc_left + wrap_delta(req.left_count, prev_left);
                acc_right <= acc_right + wrap_delta(req.right_count, prev_right);
              end
              seen_first <= 1'b1;
              prev_left  <= req.left_count;
              prev_right <= req.right_count;
            end
            state <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          l_r     <= l_c;
          sum_r   <= sum_c;
          diff_r  <= diff_c;
          asum_r  <= asum_w[25:0];
          adiff_r <= adiff_w[25:0];
          nh_r    <= h;
          dx_r    <= '0;
          dy_r    <= '0;
          if (asum_w < 27'(thr)) begin
            mc_r  <= weo_pkg::MC_SPOT;
            state <= ST_ROT_DIV;
          end else if (adiff_w < 27'(thr) || diff_c == 27'sd0) begin
            mc_r  <= weo_pkg::MC_STRAIGHT;
            state <= ST_DIST_DIV;
          end else begin
            mc_r  <= (diff_c > 27'sd0) ? weo_pkg::MC_RIGHT : weo_pkg::MC_LEFT;
            state <= ST_PHI_MUL;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            pose_valid       <= 1'b1;
            pose.pos_x       <= px_sat;
            pose.pos_y       <= py_sat;
            pose.heading     <= hd_w[31:16];
            pose.motion_case <= mc_r;
            if (cmd_r == weo_pkg::CMD_COMMIT) begin
              ref_x       <= px_sat;
              ref_y       <= py_sat;
              ref_heading <= hd_w[31:16];
              acc_left    <= '0;
              acc_right   <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          // Launch the unit once, then advance on its done pulse
          if (!issued) begin
            issued <= 1'b1;
          end else if (unit_done) begin
            issued <= 1'b0;
            unique case (state)
              ST_ROT_DIV: begin
                nh_r  <= (l_r > 26'sd0) ? h - alu_rsp.value[31:0] : h + alu_rsp.value[31:0];
                state <= ST_FINISH;
              end
              ST_DIST_DIV: begin
                rc_mag <= clamp_travel(alu_rsp.value);
                rc_neg <= sum_r[26];
                state  <= ST_TRIG0;
              end
              ST_PHI_MUL: begin
                state <= ST_PHI_DIV;
              end
              ST_PHI_DIV: begin
                nh_r  <= diff_r[26] ? h + alu_rsp.value[31:0] : h - alu_rsp.value[31:0];
                state <= ST_RAD_DIV;
              end
              ST_RAD_DIV: begin
                rc_mag <= clamp_travel(alu_rsp.value);
                rc_neg <= sum_r[26] != (diff_r > 27'sd0);
                state  <= ST_TRIG0;
              end
              ST_TRIG0: begin
                c0_r <= trig_rsp.cos_v;
                s0_r <= trig_rsp.sin_v;
                if (mc_r == weo_pkg::MC_STRAIGHT) begin
                  t_x   <= {{2{trig_rsp.cos_v[33]}}, trig_rsp.cos_v};
                  t_y   <= {{2{trig_rsp.sin_v[33]}}, trig_rsp.sin_v};
                  state <= ST_MUL_X;
                end else begin
                  state <= ST_TRIG1;
                end
              end
              ST_TRIG1: begin
                t_x   <= {{2{trig_rsp.sin_v[33]}}, trig_rsp.sin_v} - {{2{s0_r[33]}}, s0_r};
                t_y   <= {{2{c0_r[33]}}, c0_r} - {{2{trig_rsp.cos_v[33]}}, trig_rsp.cos_v};
                state <= ST_MUL_X;
              end
              ST_MUL_X: begin
                dx_r  <= delta_x;
                state <= ST_MUL_Y;
              end
              default: begin
                dy_r  <= delta_y;
                state <= ST_FINISH;
              end
            endcase
          end
        end
      endcase
    end
  end

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state == ST_CLASS))
    else $error("accepted request did not start the sequencer");

  a_done_only_when_issued: assert property (@(posedge clk) disable iff (rst)
    (alu_rsp.done || trig_rsp.done) |-> issued)
    else $error("unit finished without a launch");

  a_pose_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> ($past(state) == ST_FINISH))
    else $error("pose raised outside finish");

  a_commit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free && cmd_r == weo_pkg::CMD_COMMIT)
      |=> (acc_left == 32'd0 && acc_right == 32'd0))
    else $error("commit left accumulators nonzero");

endmodule
